@@ hw/rtl/css_pkg.sv @@
// ----------------------------------------------------------------------------
// css_pkg
// Shared types and constants of the cluster size sampler.
// ----------------------------------------------------------------------------
package css_pkg;

    localparam logic [1:0] FUNC_LOAD_ENTRY = 2'd0;
    localparam logic [1:0] FUNC_LOAD_SET   = 2'd1;
    localparam logic [1:0] FUNC_SAMPLE     = 2'd2;

    localparam int unsigned CDF_W   = 17;
    localparam int unsigned DEPTH_W = 18;
    localparam int unsigned WIDTH_W = 16;
    localparam int unsigned DIV_W   = 37;
    localparam logic [16:0] CDF_ONE = 17'd65536;

    typedef struct packed {
        logic start;
        logic div_step;
        logic corr;
        logic walk_step;
    } css_cmd_t;

    typedef struct packed {
        logic div_done;
        logic walk_done;
    } css_sts_t;

    function automatic logic [16:0] exp_entry(input int unsigned n);
        logic [63:0] r;
        r = 64'd1 << 31;
        for (int unsigned i = 0; i < n; i++) begin
            r = (r * 64'd2017374191 + (64'd1 << 30)) >> 31;
        end
        exp_entry = 17'((r + (64'd1 << 14)) >> 15);
    endfunction

endpackage

@@ hw/rtl/css_ctrl.sv @@
// ----------------------------------------------------------------------------
// css_ctrl
// Sequencer of the sampler: accept beat, divide, correct, walk, present.
// ----------------------------------------------------------------------------
module css_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_func,
    input  logic              need_div,
    input  logic              need_corr,
    output css_pkg::css_cmd_t cmd,
    input  css_pkg::css_sts_t sts,
    output logic              m_valid,
    input  logic              m_ready
);

    typedef enum logic [2:0] {ST_IDLE, ST_DIV, ST_CORR, ST_WALK, ST_OUT} state_t;

    state_t state_reg, state_next;
    logic   valid_reg, valid_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = valid_reg;

    always_comb begin
        state_next = state_reg;
        valid_next = valid_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_func == css_pkg::FUNC_SAMPLE) begin
                    cmd.start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (!need_div) begin
                    state_next = ST_WALK;
                end else if (sts.div_done) begin
                    state_next = ST_CORR;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_CORR: begin
                cmd.corr   = need_corr;
                state_next = ST_WALK;
            end
            ST_WALK: begin
                if (sts.walk_done) begin
                    state_next = ST_OUT;
                    valid_next = 1'b1;
                end else begin
                    cmd.walk_step = 1'b1;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    valid_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

endmodule

@@ hw/rtl/css_datapath.sv @@
// ----------------------------------------------------------------------------
// css_datapath
// Tables, serial divider, exponent ROM, correction and table walk.
// ----------------------------------------------------------------------------
module css_datapath #(
    parameter int unsigned REGIONS        = 4,
    parameter int unsigned MAX_CLUSTER    = 8,
    parameter int unsigned EXP_TABLE_SIZE = 256
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     load_beat,
    input  logic [1:0]               s_func,
    input  logic [1:0]               s_region,
    input  logic                     s_axis,
    input  logic [2:0]               s_entry_index,
    input  logic signed [17:0]       s_table_value,
    input  logic [15:0]              s_edge_width_in,
    input  logic [3:0]               s_table_length,
    input  logic signed [17:0]       s_random_value,
    input  logic signed [15:0]       s_position,
    input  css_pkg::css_cmd_t        cmd,
    output css_pkg::css_sts_t        sts,
    output logic                     need_div,
    output logic                     need_corr,
    output logic [3:0]               m_cluster_size,
    output logic                     m_out_of_range
);

    localparam int unsigned SETS  = REGIONS * 2;
    localparam int unsigned SET_W = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int unsigned IDX_W = $clog2(MAX_CLUSTER);
    localparam int unsigned LEN_W = $clog2(MAX_CLUSTER + 1);
    localparam int unsigned EXP_W = $clog2(EXP_TABLE_SIZE);
    localparam int unsigned MEM_D = SETS * MAX_CLUSTER;
    localparam int unsigned MEM_W = $clog2(MEM_D);
    localparam int unsigned DW    = css_pkg::DIV_W;
    localparam int unsigned CW    = 20;

    logic [css_pkg::CDF_W-1:0]   cdf_mem [MEM_D];
    logic [LEN_W-1:0]            len_reg   [SETS];
    logic [css_pkg::DEPTH_W-1:0] depth_reg [SETS];
    logic [css_pkg::WIDTH_W-1:0] width_reg [SETS];

    logic [16:0] exp_rom [EXP_TABLE_SIZE];
    always_comb begin
        for (int unsigned i = 0; i < EXP_TABLE_SIZE; i++) begin
            exp_rom[i] = css_pkg::exp_entry(i);
        end
    end

    logic [1:0] in_region;
    always_comb begin
        in_region = s_region;
        for (int unsigned i = 0; i < 3; i++) begin
            if ({30'd0, in_region} >= REGIONS) in_region = in_region - 2'(REGIONS);
        end
    end

    logic [SET_W-1:0] in_set;
    assign in_set = SET_W'({in_region, s_axis});

    logic [LEN_W-1:0] in_len;
    always_comb begin
        if (s_table_length == 4'd0) in_len = LEN_W'(1);
        else if ({28'd0, s_table_length} > MAX_CLUSTER) in_len = LEN_W'(MAX_CLUSTER);
        else in_len = LEN_W'(s_table_length);
    end

    logic [css_pkg::CDF_W-1:0] in_cdf;
    always_comb begin
        if (s_table_value < 0) in_cdf = '0;
        else if (s_table_value > 18'sd65536) in_cdf = css_pkg::CDF_ONE;
        else in_cdf = s_table_value[16:0];
    end

    logic entry_ok;
    assign entry_ok = ({29'd0, s_entry_index} < MAX_CLUSTER);

    // sample context
    logic [SET_W-1:0]          set_reg;
    logic [LEN_W-1:0]          slen_reg;
    logic signed [17:0]        rnd_reg;
    logic                      oor_reg;
    logic                      fast_reg;
    logic [css_pkg::CDF_W-1:0] c1_reg;
    logic [IDX_W-1:0]          idx_reg;
    logic signed [CW-1:0]      mag_reg;
    logic [DW-1:0]             rem_reg, quo_reg, den_reg;
    logic [5:0]                cnt_reg;
    logic                      c1_valid_reg;
    logic [31:0]               x2_reg;
    logic                      walk_done_reg;

    logic [css_pkg::CDF_W-1:0] rd_reg;
    logic [MEM_W-1:0]          rd_addr;

    always_comb begin
        if (cmd.start) rd_addr = MEM_W'(in_set * MAX_CLUSTER + 1);
        else rd_addr = MEM_W'(set_reg * MAX_CLUSTER + idx_reg);
    end

    always_ff @(posedge aclk) begin
        if (load_beat && s_func == css_pkg::FUNC_LOAD_ENTRY && entry_ok) begin
            cdf_mem[MEM_W'(in_set * MAX_CLUSTER + s_entry_index)] <= in_cdf;
        end
        rd_reg <= cdf_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int unsigned i = 0; i < SETS; i++) begin
                len_reg[i]   <= LEN_W'(1);
                depth_reg[i] <= '0;
                width_reg[i] <= '0;
            end
        end else if (load_beat && s_func == css_pkg::FUNC_LOAD_SET) begin
            len_reg[in_set]   <= in_len;
            depth_reg[in_set] <= s_table_value;
            width_reg[in_set] <= s_edge_width_in;
        end
    end

    logic signed [17:0] cur_depth;
    logic [15:0]        cur_width;
    assign cur_depth = depth_reg[set_reg];
    assign cur_width = width_reg[set_reg];

    logic [31:0] w2;
    assign w2 = 32'(cur_width) * 32'(cur_width);

    assign need_div  = !oor_reg && !fast_reg && cur_width != '0 && cur_depth < 0;
    assign need_corr = 1'b1;

    logic [DW-1:0] rem_sh, rem_sub;
    assign rem_sh  = {rem_reg[DW-2:0], quo_reg[DW-1]};
    assign rem_sub = rem_sh - den_reg;

    // fast path decided once c1 is known (in the cycle after start)
    logic fast_now;
    assign fast_now = (slen_reg >= LEN_W'(3)) && ($signed({1'b0, rd_reg}) < rnd_reg);

    logic [EXP_W-1:0] ev_addr;
    logic             ev_ok;
    assign ev_ok   = (quo_reg < DW'(EXP_TABLE_SIZE));
    assign ev_addr = EXP_W'(quo_reg);

    logic [33:0] prod;
    assign prod = 34'(-{{16{cur_depth[17]}}, cur_depth}) * (ev_ok ? exp_rom[ev_addr] : 17'd0)
                  + 34'd32768;

    // walk: compare entry idx (rd_reg when from memory or corrected entries)
    logic signed [CW-1:0] cur_c;
    always_comb begin
        cur_c = CW'(rd_reg);
        if (!fast_reg && idx_reg == '0) cur_c = CW'(rd_reg) - mag_reg;
        else if (!fast_reg && idx_reg == IDX_W'(1)) cur_c = CW'(c1_reg) + mag_reg;
    end

    logic at_end;
    assign at_end = ({1'b0, idx_reg} >= (slen_reg - LEN_W'(1)));

    assign sts.div_done  = (cnt_reg == 6'd0) && c1_valid_reg;
    assign sts.walk_done = walk_done_reg;

    assign m_cluster_size = 4'(idx_reg) + 4'd1;
    assign m_out_of_range = oor_reg;

    logic walking_reg;
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            set_reg       <= in_set;
            slen_reg      <= len_reg[in_set];
            rnd_reg       <= s_random_value;
            oor_reg       <= (s_random_value < 0) || (s_random_value > 18'sd65536);
            idx_reg       <= '0;
            mag_reg       <= '0;
            c1_valid_reg  <= 1'b0;
            fast_reg      <= 1'b0;
            walking_reg   <= 1'b0;
            walk_done_reg <= 1'b0;
            x2_reg        <= 32'(s_position * s_position);
            cnt_reg       <= 6'(DW);
        end else if (!c1_valid_reg) begin
            c1_reg       <= rd_reg;
            c1_valid_reg <= 1'b1;
            fast_reg     <= fast_now;
            rem_reg      <= '0;
            quo_reg      <= DW'({x2_reg, 4'd0}) + DW'(w2);
            den_reg      <= DW'({w2, 1'b0});
            idx_reg      <= fast_now ? IDX_W'(1) : '0;
        end else begin
            if (cmd.div_step && cnt_reg != 6'd0) begin
                cnt_reg <= cnt_reg - 6'd1;
                if (!rem_sub[DW-1]) begin
                    rem_reg <= rem_sub;
                    quo_reg <= {quo_reg[DW-2:0], 1'b1};
                end else begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[DW-2:0], 1'b0};
                end
            end
            if (cmd.corr) begin
                mag_reg <= CW'(prod >> 16);
            end
            if (cmd.walk_step) begin
                if (oor_reg) begin
                    idx_reg       <= '0;
                    walk_done_reg <= 1'b1;
                end else if (!walking_reg) begin
                    // load entry idx into rd_reg
                    walking_reg <= 1'b1;
                end else if (at_end || !(cur_c < CW'(rnd_reg))) begin
                    walk_done_reg <= 1'b1;
                end else begin
                    walking_reg <= 1'b0;
                    idx_reg     <= idx_reg + IDX_W'(1);
                end
            end
        end
    end

endmodule

@@ hw/rtl/cluster_size_sampler_top.sv @@
// ----------------------------------------------------------------------------
// cluster_size_sampler_top
// Cluster size draw by inverse-CDF search over loaded cumulative tables.
// ----------------------------------------------------------------------------
// Input beats (s_valid/s_ready) carry load or sample items; load beats and
// unused codes are absorbed and give no result. A sample beat gives one
// result beat (m_valid/m_ready) with cluster_size and out_of_range. For a
// sample, a 37-step serial divider forms the exponent ROM address when the
// edge correction applies, then the table walk reads the cumulative entries
// one at a time, loading each entry before it is compared.
// One sample is in flight at a time; s_ready stays low until the result
// beat is taken and rises the cycle after, so a stalled receiver holds
// the block.
// Reset (aresetn low, synchronous) sets lengths to one, clears edge
// settings and control; cumulative entries must be loaded before use.
// ----------------------------------------------------------------------------
module cluster_size_sampler_top #(
    parameter int unsigned REGIONS        = 4,
    parameter int unsigned MAX_CLUSTER    = 8,
    parameter int unsigned EXP_TABLE_SIZE = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_func,
    input  logic [1:0]         s_region,
    input  logic               s_axis,
    input  logic [2:0]         s_entry_index,
    input  logic signed [17:0] s_table_value,
    input  logic [15:0]        s_edge_width_in,
    input  logic [3:0]         s_table_length,
    input  logic signed [17:0] s_random_value,
    input  logic signed [15:0] s_position,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [3:0]         m_cluster_size,
    output logic               m_out_of_range
);

    css_pkg::css_cmd_t cmd;
    css_pkg::css_sts_t sts;
    logic need_div, need_corr;

    css_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_func,
        .need_div, .need_corr, .cmd, .sts, .m_valid, .m_ready
    );

    css_datapath #(
        .REGIONS(REGIONS), .MAX_CLUSTER(MAX_CLUSTER), .EXP_TABLE_SIZE(EXP_TABLE_SIZE)
    ) u_dp (
        .aclk, .aresetn,
        .load_beat(s_valid && s_ready),
        .s_func, .s_region, .s_axis, .s_entry_index, .s_table_value,
        .s_edge_width_in, .s_table_length, .s_random_value, .s_position,
        .cmd, .sts, .need_div, .need_corr, .m_cluster_size, .m_out_of_range
    );

endmodule
